// File: design/warmup_moving_average_top_assert.svh
// Assertion macros for the warmup moving average top level.
// Plain text macros only; clock aclk and reset aresetn come from the including scope.
`ifndef WARMUP_MOVING_AVERAGE_TOP_ASSERT_SVH
`define WARMUP_MOVING_AVERAGE_TOP_ASSERT_SVH

// same-cycle implication
`define WMA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wma_pkg.sv
// Shared constants, types and state encoding for the warmup moving average.
// No dependencies.
`default_nettype none

package wma_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 7;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int TOTAL_W    = 22;
    localparam int DIV_STEPS  = TOTAL_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] WINDOW_RESET = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] WINDOW_MAX   = COUNT_W'(MAX_WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIV,
        ST_OUT
    } wma_state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic div_start;
    } wma_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wma_div_stat_t;

endpackage

`default_nettype wire

// File: design/wma_window.sv
// Sample window: circular sample memory, write slot, fill count and running total.
// Depends on wma_pkg.
`default_nettype none

module wma_window
    import wma_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_write,
    input  wire logic [COUNT_W-1:0]         cfg_size,
    input  wire wma_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic signed [TOTAL_W-1:0]       total,
    output logic [COUNT_W-1:0]              count
);

    logic [SAMPLE_W-1:0]       window_mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0]       old_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W-1:0]         write_slot_reg, write_slot_next;
    logic [COUNT_W-1:0]        size_reg, size_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic [SLOT_W-1:0]         cur_slot;
    logic [COUNT_W-1:0]        slot_inc;
    logic                      full;

    // clamp of the written size into 1..MAX_WINDOW
    always_comb begin
        if (cfg_size == '0) begin
            size_next = COUNT_W'(1);
        end else if (cfg_size > WINDOW_MAX) begin
            size_next = WINDOW_MAX;
        end else begin
            size_next = cfg_size;
        end
    end

    always_comb begin
        if ({1'b0, write_slot_reg} >= size_reg) begin
            cur_slot = '0;
        end else begin
            cur_slot = write_slot_reg;
        end
    end

    assign full     = (count_reg >= size_reg);
    assign slot_inc = {1'b0, slot_reg} + COUNT_W'(1);

    always_comb begin
        count_next      = count_reg;
        total_next      = total_reg + TOTAL_W'(sample_reg);
        write_slot_next = (slot_inc >= size_reg) ? '0 : slot_inc[SLOT_W-1:0];
        if (full) begin
            total_next = total_reg - TOTAL_W'(signed'(old_reg)) + TOTAL_W'(sample_reg);
        end else begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            old_reg    <= window_mem[cur_slot];
            sample_reg <= sample;
            slot_reg   <= cur_slot;
        end
        if (ctrl.update) begin
            window_mem[slot_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg       <= WINDOW_RESET;
            count_reg      <= '0;
            write_slot_reg <= '0;
            total_reg      <= '0;
        end else if (cfg_write) begin
            size_reg       <= size_next;
            count_reg      <= '0;
            write_slot_reg <= '0;
            total_reg      <= '0;
        end else if (ctrl.update) begin
            count_reg      <= count_next;
            write_slot_reg <= write_slot_next;
            total_reg      <= total_next;
        end
    end

    assign total = total_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// File: design/wma_div.sv
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on wma_pkg.
`default_nettype none

module wma_div
    import wma_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic signed [TOTAL_W-1:0]  dividend,
    input  wire logic [COUNT_W-1:0]         divisor,
    output wma_div_stat_t                   stat,
    output logic signed [SAMPLE_W-1:0]      quotient
);

    logic [TOTAL_W-1:0]   q_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   dvs_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [COUNT_W:0]     trial;
    logic                 fits;
    logic [COUNT_W:0]     diff;
    logic [SAMPLE_W-1:0]  q_low;

    assign trial = {rem_reg, q_reg[TOTAL_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend[TOTAL_W-1] ? TOTAL_W'(-dividend) : dividend;
            neg_reg <= dividend[TOTAL_W-1];
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            q_reg   <= {q_reg[TOTAL_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q_low     = q_reg[SAMPLE_W-1:0];
    assign quotient  = neg_reg ? signed'(-q_low) : signed'(q_low);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: design/warmup_moving_average_top.sv
// Moving average over the last window_size signed samples, averaging over fewer while the
// window fills. After a sample transfer, ST_UPDATE updates the window memory and running
// total, ST_START loads the divider, ST_DIV waits on the bit-serial divider (one quotient bit
// per cycle) until its done flag, and ST_OUT loads the output register; m_valid and s_ready
// rise together, and no new sample is taken before the last one's result is loaded. A result
// waiting in the output register holds off the next sample only once the following result is
// ready and still cannot be loaded; the input then stays stalled until m_ready. A cfg_data
// transfer sets the window size (0 reads as 1, above 64 as 64) and restarts the fill; issue it
// only while no sample is in flight.
`default_nettype none
`include "warmup_moving_average_top_assert.svh"

module warmup_moving_average_top
    import wma_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [COUNT_W-1:0]         cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_average,
    output logic [COUNT_W-1:0]              m_samples_used
);

    wma_state_t                 state_reg, state_next;
    wma_ctrl_t                  ctrl;
    wma_div_stat_t              div_stat;
    logic signed [TOTAL_W-1:0]  total;
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] quotient;
    logic                       out_load;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_average_reg;
    logic [COUNT_W-1:0]         m_samples_used_reg;

    assign cfg_ready = 1'b1;

    wma_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_write(cfg_valid & cfg_ready),
        .cfg_size (cfg_data),
        .ctrl     (ctrl),
        .sample   (s_sample),
        .total    (total),
        .count    (count)
    );

    wma_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .dividend(total),
        .divisor (count),
        .stat    (div_stat),
        .quotient(quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ctrl.load      = 1'b0;
        ctrl.update    = 1'b0;
        ctrl.div_start = 1'b0;
        s_ready        = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ctrl.update = 1'b1;
                state_next  = ST_START;
            end
            ST_START: begin
                ctrl.div_start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_average_reg      <= quotient;
            m_samples_used_reg <= count;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_average      = m_average_reg;
    assign m_samples_used = m_samples_used_reg;

    `WMA_ASSERT_SAME(a_no_accept_in_div, div_stat.busy, !s_ready, "sample taken in division")
    `WMA_ASSERT_NEXT(a_accept_to_update, s_valid && s_ready, state_reg == ST_UPDATE, "no update")
    `WMA_ASSERT_NEXT(a_load_valid, out_load, m_valid && m_samples_used != '0, "empty result")
    `WMA_ASSERT_SAME(a_done_only_in_div, div_stat.done, state_reg == ST_DIV, "stray done")

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for warmup_moving_average_top: random and corner-case samples
// across many window sizes, results checked against an in-bench predictor.
// Depends on wma_pkg and the warmup_moving_average_top RTL.
module testbench;
    import wma_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;

    typedef enum {
        STYLE_RANDOM,
        STYLE_EXTREME,
        STYLE_SMALL,
        STYLE_PINNED,
        STYLE_NEGATIVE
    } sample_style_t;

    typedef enum {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_RUNS
    } rx_mode_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic [COUNT_W-1:0]         samples_used;
    } average_result_t;

    class average_scoreboard;
        logic signed [SAMPLE_W-1:0] window_mem [MAX_WINDOW];
        int window_len;
        int fill;
        int slot;
        int total;
        int errors;
        int noted;
        int checked;
        int restarts;
        average_result_t expected_averages[$];

        function new();
            window_len = int'(WINDOW_RESET);
            fill = 0;
            slot = 0;
            total = 0;
            errors = 0;
            noted = 0;
            checked = 0;
            restarts = 0;
        endfunction

        function void restart_window(logic [COUNT_W-1:0] value);
            int size;
            size = int'(value);
            if (size == 0) begin
                size = 1;
            end
            if (size > MAX_WINDOW) begin
                size = MAX_WINDOW;
            end
            window_len = size;
            fill = 0;
            slot = 0;
            total = 0;
            restarts++;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] sample);
            average_result_t exp_result;
            if (slot >= window_len) begin
                slot = 0;
            end
            if (fill >= window_len) begin
                total -= int'(window_mem[slot]);
            end else begin
                fill++;
            end
            window_mem[slot] = sample;
            total += int'(sample);
            slot++;
            if (slot >= window_len) begin
                slot = 0;
            end
            exp_result.average = SAMPLE_W'(total / fill);
            exp_result.samples_used = COUNT_W'(fill);
            expected_averages.push_back(exp_result);
            noted++;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] average,
                                   logic [COUNT_W-1:0] samples_used);
            average_result_t exp_result;
            if (expected_averages.size() == 0) begin
                $error("result transfer with nothing expected: average %0d, samples_used %0d",
                       average, samples_used);
                errors++;
            end else begin
                exp_result = expected_averages.pop_front();
                checked++;
                if (average !== exp_result.average) begin
                    $error("average: expected %0d, got %0d", exp_result.average, average);
                    errors++;
                end
                if (samples_used !== exp_result.samples_used) begin
                    $error("samples_used: expected %0d, got %0d",
                           exp_result.samples_used, samples_used);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [COUNT_W-1:0]         cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_average;
    logic [COUNT_W-1:0]         m_samples_used;

    int cycle_count = 0;
    int hold_requests = 0;
    average_scoreboard scoreboard = new();

    warmup_moving_average_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_samples_used (m_samples_used)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        s_sample <= value;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_sample(value);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (scoreboard.pending() != 0);
    endtask

    // one or more back-to-back writes of one value; each restarts the filter
    task automatic write_window(input logic [COUNT_W-1:0] value, input int writes);
        for (int i = 0; i < writes; i++) begin
            cfg_data <= value;
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            scoreboard.restart_window(value);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] make_sample(
        input sample_style_t style, input logic signed [SAMPLE_W-1:0] pinned);
        logic signed [SAMPLE_W-1:0] value;
        value = SAMPLE_W'($urandom);
        case (style)
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: value = 16'sh7FFF;
                    1: value = 16'sh8000;
                    2: value = -16'sd1;
                    3: value = 16'sd0;
                    default: value = 16'sd1;
                endcase
            end
            STYLE_SMALL: value = SAMPLE_W'(int'($urandom_range(0, 20)) - 10);
            STYLE_PINNED: value = pinned;
            STYLE_NEGATIVE: value = SAMPLE_W'(-int'($urandom_range(0, 32768)));
            default: ;
        endcase
        return value;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd2;
            3: return 7'd63;
            4: return 7'd64;
            5: return 7'd65;
            6: return 7'd127;
            7: return COUNT_W'($urandom_range(0, 127));
            default: return COUNT_W'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic run_phase(input logic [COUNT_W-1:0] window_value, input int writes,
                             input sample_style_t style,
                             input logic signed [SAMPLE_W-1:0] pinned,
                             input int count, input bit long_hold);
        int burst_left;
        burst_left = $urandom_range(1, 60);
        write_window(window_value, writes);
        if (long_hold) begin
            hold_requests <= hold_requests + 1;
        end
        for (int i = 0; i < count; i++) begin
            send_sample(make_sample(style, pinned));
            burst_left--;
            if (!long_hold && burst_left == 0) begin
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end else if ($urandom_range(0, 3) != 0) begin
                    pause_sender($urandom_range(1, 40));
                end
                burst_left = $urandom_range(1, 60);
            end
        end
    endtask

    // result side: random stall patterns plus requested long hold-offs
    initial begin
        rx_mode_t rx_mode;
        int mode_left;
        int stall_left;
        int hold_left;
        int holds_seen;
        logic ready_next;
        m_ready = 1'b0;
        rx_mode = RX_ALWAYS;
        mode_left = 0;
        stall_left = 0;
        hold_left = 0;
        holds_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                scoreboard.check_result(m_average, m_samples_used);
            end
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            ready_next = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                case (rx_mode)
                    RX_COIN: ready_next = 1'($urandom_range(0, 1));
                    RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
                    RX_RUNS: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            ready_next = 1'b0;
                        end else if ($urandom_range(0, 3) == 0) begin
                            stall_left = $urandom_range(1, 40);
                        end
                    end
                    default: ;
                endcase
            end
            m_ready <= ready_next;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d results outstanding",
               cycle_count, scoreboard.pending());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic signed [SAMPLE_W-1:0] directed[$];
        logic signed [SAMPLE_W-1:0] pinned;
        int target;
        int chunk;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window of 8: extremes, fill and first drop
        directed = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sd0, -16'sd1, 16'sd1,
                     16'sh8000, 16'sh8000, 16'sd7};
        foreach (directed[i]) send_sample(directed[i]);
        // zero reads as one
        wait_drained();
        write_window(7'd0, 1);
        directed = '{16'sh8000, 16'sh7FFF, -16'sd1};
        foreach (directed[i]) send_sample(directed[i]);
        // oversize clamps to max, repeated write, negative samples
        wait_drained();
        write_window(7'd127, 2);
        directed = '{-16'sd7, 16'sd3};
        foreach (directed[i]) send_sample(directed[i]);
        wait_drained();
        write_window(7'd65, 1);
        directed = '{16'sd5, -16'sd2};
        foreach (directed[i]) send_sample(directed[i]);

        // full-scale totals; first one with the receiver held off
        wait_drained();
        run_phase(7'd127, 1, STYLE_PINNED, 16'sh8000, 80, 1'b1);
        wait_drained();
        run_phase(7'd64, 1, STYLE_PINNED, 16'sh7FFF, 80, 1'b0);

        target = RANDOM_ITEMS;
        while (scoreboard.noted < target) begin
            wait_drained();
            pinned = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            chunk = $urandom_range(10, 160);
            if (chunk > target - scoreboard.noted) begin
                chunk = target - scoreboard.noted;
            end
            run_phase(pick_window(), ($urandom_range(0, 7) == 0) ? 2 : 1,
                      sample_style_t'($urandom_range(0, 4)), pinned,
                      chunk, $urandom_range(0, 11) == 0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (scoreboard.pending() != 0) begin
            $error("%0d expected results never arrived", scoreboard.pending());
        end
        $display("Covered %0d samples over %0d window writes, sizes 1 to %0d.",
                 scoreboard.noted, scoreboard.restarts, MAX_WINDOW);
        $display("Compared %0d results; %0d mismatches.", scoreboard.checked,
                 scoreboard.errors);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: warmup_moving_average_top.f
+incdir+design
design/wma_pkg.sv
design/wma_window.sv
design/wma_div.sv
design/warmup_moving_average_top.sv
bench/testbench.sv
